[sv/mbenc_pkg.sv]
package mbenc_pkg;

    // Fixed field widths.
    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 19;
    localparam int NEXT_W      = SIZE_W + 1;
    localparam int CRC_W       = 16;
    localparam int KIND_W      = 3;
    localparam int CFG_INDEX_W = 1;

    // Session geometry.
    localparam int HEADER_BYTES    = 192;
    localparam int MAX_IMAGE_BYTES = 262144;
    localparam int QUEUE_DEPTH     = 4;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SESSION_KEY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_BYTES = 1'd1;

    // Input operations.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_LOCAL_KEY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IMAGE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHECKSUM  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd4;

    // Cipher constants.
    localparam logic [WORD_W-1:0] KEY_MULT    = 32'h6177614B;
    localparam logic [WORD_W-1:0] STREAM_XOR  = 32'h20796220;
    localparam logic [WORD_W-1:0] OFFSET_BIAS = 32'h0200_0000;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'h15A0;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'ha1c1;
    localparam logic [SIZE_W-1:0] IMAGE_BYTES_RESET = 19'd192;

    // Local key derivation constants. The two byte keys are given with the
    // byte for the lowest lane in the lowest bits, which already folds in the
    // byte swap applied on the link.
    localparam logic [WORD_W-1:0] LK_SIZE_BIAS = 32'h200;
    localparam logic [WORD_W-1:0] LK_FIXED     = 32'h0038_0000;
    localparam logic [WORD_W-1:0] LK_HIGH_BITS = 32'h8080_8080;
    localparam logic [WORD_W-1:0] LK_KEY_LOW   = 32'h6177614B;
    localparam logic [WORD_W-1:0] LK_KEY_HIGH  = 32'h6F646573;

    // One queue entry: an item already classified by the front, with every
    // operand the back needs to form its one or two results.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              encrypt;
        logic              has_chk;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] key_a;
        logic [NEXT_W-1:0] off_a;
        logic [WORD_W-1:0] chk;
        logic [WORD_W-1:0] key_b;
        logic [NEXT_W-1:0] off_b;
    } entry_t;

    // Byte-swapped local key for a padded image size.
    function automatic logic [WORD_W-1:0] local_key(input logic [WORD_W-1:0] padded);
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] b;
        s   = (padded - LK_SIZE_BIAS) >> 3;
        a   = ((s & 32'h3F80) << 1) | ((s & 32'h4000) << 2) | (s & 32'h7F) | LK_FIXED;
        sum = (a >> 8) + (a >> 16) + a;
        b   = (sum << 24) | a | LK_HIGH_BITS;
        return b[9] ? (b ^ LK_KEY_HIGH) : (b ^ LK_KEY_LOW);
    endfunction

    // Bit-serial checksum over one word, LSB first. It is linear, so the
    // unrolled form is a plain XOR network.
    function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc,
                                                  input logic [WORD_W-1:0] v);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = 0; i < WORD_W; i++) begin
            fb = c[0] ^ v[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Key stream word combined with the negated offset term.
    function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] key,
                                                    input logic [NEXT_W-1:0] off);
        logic [WORD_W-1:0] biased;
        biased = {{(WORD_W-NEXT_W){1'b0}}, off} + OFFSET_BIAS;
        return key ^ (32'd0 - biased) ^ STREAM_XOR;
    endfunction

endpackage

[sv/mbenc_front.sv]
module mbenc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbenc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbenc_pkg::WORD_W-1:0]          cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mbenc_pkg::WORD_W-1:0]          s_tdata,
    input  logic [0:0]                            s_tuser,
    input  logic                                  queue_full,
    output logic                                  push,
    output mbenc_pkg::entry_t                     entry
);

    logic [mbenc_pkg::WORD_W-1:0] session_key_reg, session_key_next;
    logic [mbenc_pkg::SIZE_W-1:0] image_bytes_reg, image_bytes_next;
    logic [mbenc_pkg::SIZE_W-1:0] offset_reg, offset_next;
    logic [mbenc_pkg::WORD_W-1:0] next_key_reg, next_key_next;
    logic [mbenc_pkg::CRC_W-1:0]  crc_reg, crc_next;
    logic                         finished_reg, finished_next;

    logic [mbenc_pkg::SIZE_W-1:0] size_wr;
    logic [mbenc_pkg::NEXT_W-1:0] next_off;
    logic [mbenc_pkg::NEXT_W-1:0] padded;
    logic                         in_header;
    logic                         past_end;
    logic                         done;
    logic [mbenc_pkg::WORD_W-1:0] msg;
    logic [mbenc_pkg::CRC_W-1:0]  crc_new;
    logic [mbenc_pkg::WORD_W-1:0] mult_in;
    logic [mbenc_pkg::WORD_W-1:0] mult_out;
    logic                         is_begin;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign push      = s_tvalid && s_tready;
    assign is_begin  = (s_tuser[0] == mbenc_pkg::OP_BEGIN);

    assign size_wr   = cfg_data[mbenc_pkg::SIZE_W-1:0];
    assign next_off  = {1'b0, offset_reg} + mbenc_pkg::NEXT_W'(4);
    assign padded    = ({1'b0, image_bytes_reg} + mbenc_pkg::NEXT_W'(7))
                       & ~mbenc_pkg::NEXT_W'(7);
    assign in_header = offset_reg < mbenc_pkg::SIZE_W'(mbenc_pkg::HEADER_BYTES);
    assign past_end  = offset_reg >= image_bytes_reg;
    assign done      = (next_off >= mbenc_pkg::NEXT_W'(mbenc_pkg::HEADER_BYTES))
                       && (next_off >= padded);
    assign msg       = past_end ? '0 : s_tdata;
    assign crc_new   = mbenc_pkg::crc_word(crc_reg, msg);

    // The one key multiplier: it loads the session key on a begin and
    // otherwise steps the key one word ahead.
    assign mult_in  = is_begin ? session_key_reg : next_key_reg;
    assign mult_out = mult_in * mbenc_pkg::KEY_MULT + 32'd1;

    always_comb
    begin
        session_key_next = session_key_reg;
        image_bytes_next = image_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbenc_pkg::REG_SESSION_KEY:
                begin
                    session_key_next = cfg_data;
                end
                mbenc_pkg::REG_IMAGE_BYTES:
                begin
                    if ({13'd0, size_wr} > 32'(mbenc_pkg::MAX_IMAGE_BYTES))
                    begin
                        image_bytes_next = mbenc_pkg::SIZE_W'(mbenc_pkg::MAX_IMAGE_BYTES);
                    end
                    else
                    begin
                        image_bytes_next = size_wr;
                    end
                end
                default:
                begin
                    session_key_next = session_key_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        offset_next   = offset_reg;
        next_key_next = next_key_reg;
        crc_next      = crc_reg;
        finished_next = finished_reg;

        entry         = '0;
        entry.key_a   = next_key_reg;
        entry.off_a   = {1'b0, offset_reg};
        entry.off_b   = next_off;
        entry.chk     = {image_bytes_reg[15:0], in_header ? crc_reg : crc_new};
        entry.key_b   = in_header ? next_key_reg : mult_out;

        if (is_begin)
        begin
            entry.kind = mbenc_pkg::KIND_LOCAL_KEY;
            entry.word = mbenc_pkg::local_key({12'd0, padded});
        end
        else if (finished_reg)
        begin
            entry.kind = mbenc_pkg::KIND_REJECTED;
        end
        else if (in_header)
        begin
            entry.kind    = mbenc_pkg::KIND_HEADER;
            entry.word    = s_tdata;
            entry.has_chk = done;
        end
        else
        begin
            entry.kind    = mbenc_pkg::KIND_IMAGE;
            entry.word    = msg;
            entry.encrypt = 1'b1;
            entry.has_chk = done;
        end

        if (push)
        begin
            if (is_begin)
            begin
                offset_next   = '0;
                next_key_next = mult_out;
                crc_next      = mbenc_pkg::CRC_INIT;
                finished_next = 1'b0;
            end
            else if (!finished_reg)
            begin
                offset_next   = next_off[mbenc_pkg::SIZE_W-1:0];
                finished_next = done;
                if (!in_header)
                begin
                    next_key_next = mult_out;
                    crc_next      = crc_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key_reg <= '0;
            image_bytes_reg <= mbenc_pkg::IMAGE_BYTES_RESET;
            offset_reg      <= '0;
            next_key_reg    <= 32'd1;
            crc_reg         <= mbenc_pkg::CRC_INIT;
            finished_reg    <= 1'b0;
        end
        else
        begin
            session_key_reg <= session_key_next;
            image_bytes_reg <= image_bytes_next;
            offset_reg      <= offset_next;
            next_key_reg    <= next_key_next;
            crc_reg         <= crc_next;
            finished_reg    <= finished_next;
        end
    end

    a_begin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && is_begin) |=> (!finished_reg && offset_reg == '0))
        else $error("begin item did not restart the session");

endmodule

[sv/mbenc_queue.sv]
module mbenc_queue #(
    parameter int DEPTH = mbenc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbenc_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mbenc_pkg::entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbenc_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("item pushed into a full queue");

endmodule

[sv/mbenc_back.sv]
module mbenc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  mbenc_pkg::entry_t                 head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbenc_pkg::WORD_W-1:0]      m_tdata,
    output logic [mbenc_pkg::KIND_W-1:0]      m_tuser,
    output logic                              m_tlast
);

    logic                         valid_reg, valid_next;
    logic                         phase_reg, phase_next;
    logic [mbenc_pkg::WORD_W-1:0] word_reg;
    logic [mbenc_pkg::KIND_W-1:0] kind_reg;
    logic                         last_reg;

    logic                         load;
    logic [mbenc_pkg::WORD_W-1:0] mask;
    logic [mbenc_pkg::WORD_W-1:0] first_word;

    // A single mask unit serves the image word in the first phase and the
    // checksum word in the second.
    assign mask = mbenc_pkg::mask_word(phase_reg ? head.key_b : head.key_a,
                                       phase_reg ? head.off_b : head.off_a);
    assign first_word = head.encrypt ? (head.word ^ mask) : head.word;

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && (phase_reg || !head.has_chk);

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = !phase_reg && head.has_chk;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (phase_reg)
            begin
                word_reg <= head.chk ^ mask;
                kind_reg <= mbenc_pkg::KIND_CHECKSUM;
                last_reg <= 1'b1;
            end
            else
            begin
                word_reg <= first_word;
                kind_reg <= head.kind;
                last_reg <= !head.has_chk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    a_phase_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.has_chk))
        else $error("checksum phase without a pending entry");

    a_checksum_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == mbenc_pkg::KIND_CHECKSUM) |-> last_reg)
        else $error("checksum word not marked last");

endmodule

[sv/multiboot_image_encryptor.sv]
// After an item is accepted, its entry is written into a queue slot, and its result is then
// loaded into the output register of the back end; an entry may first wait in the queue.
// Throughput: one item per cycle while the queue is not full. The item that closes the image
// yields its word and then the checksum word, which the back end's mask unit forms.
// Reset (rst_n, asynchronous, active low) clears the queue and the output, restores the
// registers and session state to their reset values, and the block is ready at once.
module multiboot_image_encryptor #(
    parameter int QUEUE_DEPTH = mbenc_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration writes: index 0 is the session key, index 1 the image size in bytes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbenc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbenc_pkg::WORD_W-1:0]      cfg_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbenc_pkg::WORD_W-1:0]      s_tdata,   // [31:0] data_word
    input  logic [0:0]                        s_tuser,   // [0] operation
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbenc_pkg::WORD_W-1:0]      m_tdata,   // [31:0] out_word
    output logic [mbenc_pkg::KIND_W-1:0]      m_tuser,   // [2:0] word_kind
    output logic                              m_tlast    // last
);

    // The front owns all session state: the byte offset, the key stream, the
    // running checksum and the finished flag. It classifies each item as it is
    // accepted and writes a fully prepared entry into the queue, so its state
    // advances at one item per cycle while the queue has room, stalling only on a full queue.
    logic              push;
    logic              queue_full;
    mbenc_pkg::entry_t push_entry;

    // The back drains the queue into the output register. A closing item keeps its
    // entry at the head of the queue until its checksum word is loaded as well.
    logic              pop;
    logic              head_valid;
    mbenc_pkg::entry_t head;

    mbenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    mbenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mbenc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[tb/multiboot_image_encryptor_tb.sv]
`timescale 1ns / 100ps

module multiboot_image_encryptor_tb;

    // Bench timing and run length.
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 2000;

    // Cipher constants, kept apart from the package so that a wrong constant in the
    // design shows up as a mismatch instead of being shared by both sides.
    localparam logic [31:0]                  LCG_MULT  = 32'h6177_614B;
    localparam logic [31:0]                  LINK_XOR  = 32'h2079_6220;
    localparam logic [31:0]                  OFF_BIAS  = 32'h0200_0000;
    localparam logic [15:0]                  CSUM_SEED = 16'h15A0;
    localparam logic [15:0]                  CSUM_POLY = 16'hA1C1;
    localparam logic [mbenc_pkg::SIZE_W-1:0] SIZE_CAP  =
        mbenc_pkg::SIZE_W'(mbenc_pkg::MAX_IMAGE_BYTES);
    localparam logic [mbenc_pkg::SIZE_W-1:0] SIZE_INIT = 19'd192;

    // One word that the block sends on the link.
    typedef struct packed {
        logic [mbenc_pkg::WORD_W-1:0] word;
        logic [mbenc_pkg::KIND_W-1:0] kind;
        logic                         last;
    } link_word_t;

    // One row of the directed table: either a register write or a run of items.
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic                         sel;       // operation for items, register index for writes
        logic [31:0]                  data;
        logic [15:0]                  reps;
        logic                         rnd;       // fresh random data for every repetition
        logic                         typed;     // the first result is given by the row itself
        logic [mbenc_pkg::KIND_W-1:0] exp_kind;
        logic [31:0]                  exp_word;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [mbenc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbenc_pkg::WORD_W-1:0]      cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [mbenc_pkg::WORD_W-1:0]      s_tdata;
    logic [0:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [mbenc_pkg::WORD_W-1:0]      m_tdata;
    logic [mbenc_pkg::KIND_W-1:0]      m_tuser;
    logic                              m_tlast;

    // Words the block still owes on the link, oldest first.
    link_word_t link_words_due[$];
    stim_row_t  stim_rows[$];
    link_word_t got_word;
    int         mismatches  = 0;
    int         idle_cycles = 0;
    logic       eager_sender = 1'b0;

    // Shadow copy of the block: its registers and its session state.
    logic [31:0]                  model_session_key;
    logic [mbenc_pkg::SIZE_W-1:0] model_image_bytes;
    logic [mbenc_pkg::SIZE_W-1:0] model_offset;
    logic [31:0]                  model_stream_key;
    logic [15:0]                  model_checksum;
    logic                         session_closed;

    always #CLK_HALF clk = ~clk;

    multiboot_image_encryptor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Local key for a padded size. The size term wraps modulo 2^32 when the padded size
    // is below 0x200. The key words are written with the link's byte swap already folded in, so
    // on the link lane 0 of the mixed word meets its key byte in the low bits.
    function automatic logic [31:0] derive_local_key(input logic [31:0] padded);
        logic [31:0] steps;
        logic [31:0] base;
        logic [31:0] mixed;
        logic [31:0] lane_key;
        steps    = (padded - 32'h200) >> 3;
        base     = ((steps & 32'h3F80) << 1) | ((steps & 32'h4000) << 2) | (steps & 32'h7F)
                   | 32'h0038_0000;
        mixed    = (((base >> 8) + (base >> 16) + base) << 24) | base | 32'h8080_8080;
        lane_key = mixed[9] ? {8'h6F, 8'h64, 8'h65, 8'h73} : {8'h61, 8'h77, 8'h61, 8'h4B};
        return mixed ^ lane_key;
    endfunction

    // Bit-serial checksum, least significant bit of the word first.
    function automatic logic [15:0] fold_checksum(input logic [15:0] crc,
                                                  input logic [31:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 32; i++)
        begin
            c = (c[0] ^ data[i]) ? ((c >> 1) ^ CSUM_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Steps the key stream once and combines it with the negated offset term.
    function automatic logic [31:0] advance_mask(input logic [31:0] off);
        model_stream_key = model_stream_key * LCG_MULT + 32'd1;
        return model_stream_key ^ (32'd0 - (off + OFF_BIAS)) ^ LINK_XOR;
    endfunction

    // Works out what one accepted item puts on the link and queues it. A typed row
    // replaces the first predicted word with the value written in the table.
    task automatic encrypt_item(input logic op, input logic [31:0] data, input logic typed,
                                input logic [mbenc_pkg::KIND_W-1:0] t_kind,
                                input logic [31:0] t_word);
        link_word_t  first;
        link_word_t  tail;
        logic        has_tail;
        logic [31:0] padded;
        logic [31:0] plain;
        logic [19:0] nxt;
        padded   = ({13'd0, model_image_bytes} + 32'd7) & ~32'd7;
        has_tail = 1'b0;
        tail     = '0;
        first.last = 1'b1;
        if (op == mbenc_pkg::OP_BEGIN)
        begin
            model_offset     = '0;
            model_stream_key = model_session_key;
            model_checksum   = CSUM_SEED;
            session_closed   = 1'b0;
            first.word = derive_local_key(padded);
            first.kind = mbenc_pkg::KIND_LOCAL_KEY;
        end
        else if (session_closed)
        begin
            // A word after the checksum is turned away and leaves the state alone.
            first.word = '0;
            first.kind = mbenc_pkg::KIND_REJECTED;
        end
        else
        begin
            if (model_offset < mbenc_pkg::HEADER_BYTES)
            begin
                first.word = data;
                first.kind = mbenc_pkg::KIND_HEADER;
            end
            else
            begin
                // Only a word whose own offset is at or past the size is zeroed.
                plain          = (model_offset >= model_image_bytes) ? 32'd0 : data;
                model_checksum = fold_checksum(model_checksum, plain);
                first.word     = plain ^ advance_mask({13'd0, model_offset});
                first.kind     = mbenc_pkg::KIND_IMAGE;
            end
            nxt          = {1'b0, model_offset} + 20'd4;
            model_offset = nxt[mbenc_pkg::SIZE_W-1:0];
            // The checksum closes the session once the offset has passed both the
            // header and the padded size, with the size register as it is right now.
            if (nxt >= mbenc_pkg::HEADER_BYTES && {12'd0, nxt} >= padded)
            begin
                first.last     = 1'b0;
                tail.word      = {model_image_bytes[15:0], model_checksum}
                                 ^ advance_mask({12'd0, nxt});
                tail.kind      = mbenc_pkg::KIND_CHECKSUM;
                tail.last      = 1'b1;
                has_tail       = 1'b1;
                session_closed = 1'b1;
            end
        end
        if (typed)
        begin
            first.word = t_word;
            first.kind = t_kind;
            first.last = 1'b1;
        end
        link_words_due.push_back(first);
        if (has_tail)
        begin
            link_words_due.push_back(tail);
        end
    endtask

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Image sizes: mostly just past the header, some inside it, a few huge or oversized.
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return mbenc_pkg::HEADER_BYTES + 4 * $urandom_range(0, 40);
        end
        else if (r < 70)
        begin
            return mbenc_pkg::HEADER_BYTES + $urandom_range(0, 160);
        end
        else if (r < 82)
        begin
            return $urandom_range(0, mbenc_pkg::HEADER_BYTES - 1);
        end
        else if (r < 92)
        begin
            return $urandom;
        end
        else if (r < 96)
        begin
            return mbenc_pkg::MAX_IMAGE_BYTES - $urandom_range(0, 7);
        end
        return mbenc_pkg::MAX_IMAGE_BYTES + $urandom_range(1, 262143);
    endfunction

    // Offers one item on the input side after a random gap and predicts it once it has
    // been taken. The valid stays high after acceptance so that back-to-back items run.
    task automatic send_item(input logic op, input logic [31:0] data, input logic typed,
                             input logic [mbenc_pkg::KIND_W-1:0] t_kind,
                             input logic [31:0] t_word);
        int gap;
        gap = eager_sender ? 0 : idle_len();
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        encrypt_item(op, data, typed, t_kind, t_word);
    endtask

    // Brings the block to rest: no item offered, every owed word received, and then a
    // short pause for anything still inside the pipeline.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (link_words_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mbenc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == mbenc_pkg::REG_SESSION_KEY)
        begin
            model_session_key = value;
        end
        else
        begin
            // Only the low 19 bits are kept, and a size above the maximum saturates.
            model_image_bytes = (value[mbenc_pkg::SIZE_W-1:0] > SIZE_CAP)
                                ? SIZE_CAP : value[mbenc_pkg::SIZE_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic sel, input logic [31:0] data,
                           input int reps, input logic rnd, input logic typed,
                           input logic [mbenc_pkg::KIND_W-1:0] exp_kind,
                           input logic [31:0] exp_word);
        stim_row_t r;
        r.kind     = kind;
        r.sel      = sel;
        r.data     = data;
        r.reps     = 16'(reps);
        r.rnd      = rnd;
        r.typed    = typed;
        r.exp_kind = exp_kind;
        r.exp_word = exp_word;
        stim_rows.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: every word taken from the block is matched against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (link_words_due.size() == 0)
            begin
                $error("unexpected result item: out_word %h word_kind %0d last %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                got_word = link_words_due.pop_front();
                check_field("out_word", got_word.word, m_tdata);
                check_field("word_kind", {29'd0, got_word.kind}, {29'd0, m_tuser});
                check_field("last", {31'd0, got_word.last}, {31'd0, m_tlast});
            end
        end
    end

    // The receiver takes words in runs of random length, broken by stalls that are
    // mostly short. Some runs are long, so that stretches with no stall occur too.
    initial
    begin
        int run;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
            repeat (run)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            stall = idle_len();
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
        end
    end

    // Watchdog: cycles in a row in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_CYCLES);
        $display("multiboot_image_encryptor verification failed");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        int        random_items;
        int        sent;
        int        cap;
        logic      op;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;

        model_session_key = '0;
        model_image_bytes = SIZE_INIT;
        model_offset      = '0;
        model_stream_key  = '0;
        model_checksum    = CSUM_SEED;
        session_closed    = 1'b0;

        // Directed table. After reset the size is 192, so the local key is known by hand.
        // A word before any begin is handled with the reset state, at offset zero.
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'hFFFF_FFFF, 1,  0, 1,
                mbenc_pkg::KIND_HEADER,    32'hFFFF_FFFF);
        add_row(ROW_ITEM, mbenc_pkg::OP_BEGIN, 32'hDEAD_BEEF, 1,  0, 1,
                mbenc_pkg::KIND_LOCAL_KEY, 32'hFFDD_9AAB);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0000_0000, 1,  0, 1,
                mbenc_pkg::KIND_HEADER,    32'h0000_0000);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h8000_0001, 1,  0, 1,
                mbenc_pkg::KIND_HEADER,    32'h8000_0001);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0,         45, 1, 0,
                mbenc_pkg::KIND_HEADER,    32'h0);
        // The image is no larger than the header: the checksum follows the last header word.
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h5A5A_A5A5, 1,  0, 0,
                mbenc_pkg::KIND_HEADER,    32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h1234_5678, 1,  0, 1,
                mbenc_pkg::KIND_REJECTED,  32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_BEGIN, 32'h0,         1,  0, 1,
                mbenc_pkg::KIND_LOCAL_KEY, 32'hFFDD_9AAB);
        // An all-ones size saturates at the maximum; then a full-scale session key.
        add_row(ROW_CFG,  mbenc_pkg::REG_IMAGE_BYTES, 32'hFFFF_FFFF, 0, 0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_CFG,  mbenc_pkg::REG_SESSION_KEY, 32'hFFFF_FFFF, 0, 0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_BEGIN, 32'h0,         1,  0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0,         48, 1, 0,
                mbenc_pkg::KIND_HEADER,    32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'hFFFF_FFFF, 1,  0, 0,
                mbenc_pkg::KIND_IMAGE,     32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0000_0000, 1,  0, 0,
                mbenc_pkg::KIND_IMAGE,     32'h0);
        // The size shrinks mid-session to a value that is not a multiple of four: the word
        // at 200 is kept, the word at 204 is zeroed and closes the padded size of 208.
        add_row(ROW_CFG,  mbenc_pkg::REG_IMAGE_BYTES, 32'd202,       0, 0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'hFFFF_FFFF, 2,  0, 0,
                mbenc_pkg::KIND_IMAGE,     32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'hFFFF_FFFF, 1,  0, 1,
                mbenc_pkg::KIND_REJECTED,  32'h0);
        // Bit 19 is dropped, leaving a size of zero; the key term then wraps around.
        add_row(ROW_CFG,  mbenc_pkg::REG_SESSION_KEY, 32'h1357_9BDF, 0, 0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_CFG,  mbenc_pkg::REG_IMAGE_BYTES, 32'h0008_0000, 0, 0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_BEGIN, 32'h0,         1,  0, 0,
                mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0,         48, 1, 0,
                mbenc_pkg::KIND_HEADER,    32'h0);
        add_row(ROW_ITEM, mbenc_pkg::OP_WORD,  32'h0000_0000, 1,  0, 1,
                mbenc_pkg::KIND_REJECTED,  32'h0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                write_reg(row.sel, row.data);
            end
            else
            begin
                repeat (row.reps)
                begin
                    send_item(row.sel, row.rnd ? $urandom : row.data, row.typed,
                              row.exp_kind, row.exp_word);
                end
            end
        end

        // Random phases. Each one starts from rest, often with new register values, and most
        // run a well-formed session with random content up to its checksum and a few
        // words past it. Some continue the previous session, so that a size change lands
        // mid-session, and a little noise puts a begin in the middle of an image.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            drain_results();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(mbenc_pkg::REG_SESSION_KEY, $urandom);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(mbenc_pkg::REG_IMAGE_BYTES, pick_size());
            end
            eager_sender = ($urandom_range(0, 4) == 0);
            sent = 0;
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(mbenc_pkg::OP_BEGIN, $urandom, 1'b0, mbenc_pkg::KIND_LOCAL_KEY,
                          32'h0);
                sent++;
            end
            cap = $urandom_range(30, 160);
            while (!session_closed && sent < cap)
            begin
                op = ($urandom_range(0, 39) == 0) ? 1'($urandom_range(0, 1))
                                                  : mbenc_pkg::OP_WORD;
                send_item(op, pick_word(), 1'b0, mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
                sent++;
            end
            if (session_closed)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    send_item(mbenc_pkg::OP_WORD, pick_word(), 1'b0,
                              mbenc_pkg::KIND_LOCAL_KEY, 32'h0);
                    sent++;
                end
            end
            random_items += sent;
        end

        // Wait for every owed word and a few cycles more, so that a stray extra result
        // still gets caught. The watchdog ends the run if the block hangs.
        drain_results();
        if (mismatches == 0)
        begin
            $display("multiboot_image_encryptor verification clean");
        end
        else
        begin
            $display("multiboot_image_encryptor verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mbenc_pkg.sv
sv/mbenc_front.sv
sv/mbenc_queue.sv
sv/mbenc_back.sv
sv/multiboot_image_encryptor.sv
tb/multiboot_image_encryptor_tb.sv
